// ----- rtl/core/nes_pkg.sv -----
// nes_pkg: shared constants and the queue entry type for the nal escape and slice splitter
// used by nes_front, nes_fifo, nes_back and the top level; depends on nothing
package nes_pkg;

  localparam int HOLD_DEPTH  = 4;
  localparam int CNT_W       = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QFILL_W     = 3;

  localparam logic [7:0] EPB_BYTE = 8'h03;
  localparam logic [7:0] SC_ZERO  = 8'h00;
  localparam logic [7:0] SC_ONE   = 8'h01;

  localparam logic [1:0] RUN_SAT        = 2'd2;
  localparam logic [2:0] OFFSET_MAX     = 3'd7;
  localparam logic [2:0] CUT_MIN_OFFSET = 3'd3;

  // one classified input beat, as handed from the front to the back
  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic        start_code;
    logic        epb;
    logic        last;
    logic        key;
    logic [15:0] seq;
  } nes_op_t;

endpackage

// ----- rtl/core/nes_in_if.sv -----
// nes_in_if: input byte channel of the nal escape and slice splitter
// valid/ready handshake with the raw frame byte and its frame flags; no dependencies
interface nes_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        frame_first;
  logic        frame_last;
  logic        need_escape;
  logic        need_start_code;
  logic        key_frame_in;
  logic [15:0] frame_sequence;

  modport source (
    output valid, data_byte, frame_first, frame_last, need_escape, need_start_code,
           key_frame_in, frame_sequence,
    input  ready
  );
  modport sink (
    input  valid, data_byte, frame_first, frame_last, need_escape, need_start_code,
           key_frame_in, frame_sequence,
    output ready
  );
endinterface

// ----- rtl/core/nes_out_if.sv -----
// nes_out_if: output byte channel of the nal escape and slice splitter
// valid/ready handshake with the stream byte and its slice and frame marks; no dependencies
interface nes_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [15:0] slice_index;
  logic        slice_last;
  logic        frame_end;
  logic        key_frame_out;
  logic [15:0] sequence_out;

  modport source (
    output valid, out_byte, slice_index, slice_last, frame_end, key_frame_out, sequence_out,
    input  ready
  );
  modport sink (
    input  valid, out_byte, slice_index, slice_last, frame_end, key_frame_out, sequence_out,
    output ready
  );
endinterface

// ----- rtl/core/nes_cfg_if.sv -----
// nes_cfg_if: configuration write channel carrying the slicing enable
// valid/ready handshake, one register, no address; no dependencies
interface nes_cfg_if;
  logic valid;
  logic ready;
  logic slicing_enabled;

  modport source (output valid, slicing_enabled, input ready);
  modport sink   (input valid, slicing_enabled, output ready);
endinterface

// ----- rtl/core/nes_front.sv -----
// nes_front: accepts input beats, tracks frame state and escape history, classifies each beat
// depends on nes_pkg and nes_in_if
module nes_front (
  input  logic            clk,
  input  logic            rst,
  nes_in_if.sink          in_ch,
  output nes_pkg::nes_op_t op,
  output logic            op_valid,
  input  logic            op_ready
);

  logic       frame_open;
  logic       esc_held;
  logic [1:0] bytes_seen;
  logic [1:0] prev_zero;

  logic       start;
  logic       esc;
  logic [1:0] seen_cur;
  logic [1:0] zeros_cur;
  logic [1:0] zeros_base;
  logic       epb;
  logic       accept;

  assign start     = in_ch.frame_first | ~frame_open;
  assign esc       = start ? in_ch.need_escape : esc_held;
  assign seen_cur  = start ? 2'd0 : bytes_seen;
  assign zeros_cur = start ? 2'd0 : prev_zero;

  // prevention byte before a small byte that follows two zero payload bytes
  assign epb = esc && (seen_cur == nes_pkg::RUN_SAT) && (in_ch.data_byte <= nes_pkg::EPB_BYTE)
               && (zeros_cur == nes_pkg::RUN_SAT);
  assign zeros_base = epb ? 2'd0 : zeros_cur;

  assign op_valid    = in_ch.valid;
  assign in_ch.ready = op_ready;
  assign accept      = in_ch.valid & op_ready;

  always_comb begin
    op.data       = in_ch.data_byte;
    op.start      = start;
    op.start_code = start & in_ch.need_escape & in_ch.need_start_code;
    op.epb        = epb;
    op.last       = in_ch.frame_last;
    op.key        = in_ch.key_frame_in;
    op.seq        = in_ch.frame_sequence;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      esc_held   <= 1'b0;
      bytes_seen <= 2'd0;
      prev_zero  <= 2'd0;
    end else if (accept) begin
      frame_open <= ~in_ch.frame_last;
      esc_held   <= esc;
      if (esc) begin
        bytes_seen <= (seen_cur == nes_pkg::RUN_SAT) ? seen_cur : seen_cur + 2'd1;
        if (in_ch.data_byte == 8'h00) begin
          prev_zero <= (zeros_base == nes_pkg::RUN_SAT) ? zeros_base : zeros_base + 2'd1;
        end else begin
          prev_zero <= 2'd0;
        end
      end
    end
  end

endmodule

// ----- rtl/core/nes_fifo.sv -----
// nes_fifo: short queue of classified beats between the front and the back
// depends on nes_pkg
module nes_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  nes_pkg::nes_op_t wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output nes_pkg::nes_op_t rd_data
);

  nes_pkg::nes_op_t mem [nes_pkg::QUEUE_DEPTH];
  logic [nes_pkg::QPTR_W-1:0]  wr_ptr;
  logic [nes_pkg::QPTR_W-1:0]  rd_ptr;
  logic [nes_pkg::QFILL_W-1:0] fill;
  logic                        do_wr;
  logic                        do_rd;

  assign wr_ready = fill != nes_pkg::QFILL_W'(nes_pkg::QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid & wr_ready;
  assign do_rd    = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/nes_back.sv -----
// nes_back: expands queued beats into pushes through the four-byte hold-back, cuts slices,
// flushes at frame end and drives the output register; depends on nes_pkg and the interfaces
module nes_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_valid,
  output logic             rd_ready,
  input  nes_pkg::nes_op_t rd_data,
  nes_cfg_if.sink          cfg_ch,
  nes_out_if.source        out_ch
);

  typedef enum logic [3:0] {
    ST_HEAD  = 4'b0001,
    ST_SC    = 4'b0010,
    ST_BYTE  = 4'b0100,
    ST_FLUSH = 4'b1000
  } back_state_t;

  back_state_t                state;
  logic [1:0]                 sc_idx;
  logic [7:0]                 hold [nes_pkg::HOLD_DEPTH];
  logic [nes_pkg::CNT_W-1:0]  hold_count;
  logic [2:0]                 slice_offset;
  logic [15:0]                slice_counter;
  logic                       key_held;
  logic [15:0]                seq_held;
  logic                       slicing;

  logic                       out_valid;
  logic [7:0]                 out_byte;
  logic [15:0]                out_index;
  logic                       out_last;
  logic                       out_end;
  logic                       out_key;
  logic [15:0]                out_seq;

  logic                       fresh;
  logic [nes_pkg::CNT_W-1:0]  cur_count;
  logic [2:0]                 cur_offset;
  logic [15:0]                cur_counter;
  logic                       cur_key;
  logic [15:0]                cur_seq;
  logic                       active;
  logic                       flushing;
  logic                       do_push;
  logic [7:0]                 push_byte;
  logic                       full;
  logic                       emit;
  logic                       out_free;
  logic                       step;
  logic                       cut;
  logic                       flush_last;
  logic                       emit_last;
  logic                       emit_end;

  // a beat that opens a frame drops whatever the previous frame left held
  assign fresh       = (state == ST_HEAD) && rd_valid && rd_data.start;
  assign cur_count   = fresh ? '0 : hold_count;
  assign cur_offset  = fresh ? 3'd0 : slice_offset;
  assign cur_counter = fresh ? 16'd0 : slice_counter;
  assign cur_key     = fresh ? rd_data.key : key_held;
  assign cur_seq     = fresh ? rd_data.seq : seq_held;

  assign active   = (state != ST_HEAD) || rd_valid;
  assign flushing = state == ST_FLUSH;
  assign do_push  = active && !flushing;

  always_comb begin
    unique case (state)
      ST_HEAD: begin
        if (rd_data.start_code) begin
          push_byte = nes_pkg::SC_ZERO;
        end else if (rd_data.epb) begin
          push_byte = nes_pkg::EPB_BYTE;
        end else begin
          push_byte = rd_data.data;
        end
      end
      ST_SC:   push_byte = (sc_idx == 2'd3) ? nes_pkg::SC_ONE : nes_pkg::SC_ZERO;
      ST_BYTE: push_byte = rd_data.data;
      default: push_byte = rd_data.data;
    endcase
  end

  assign full       = cur_count == nes_pkg::CNT_W'(nes_pkg::HOLD_DEPTH);
  assign emit       = (do_push && full) || flushing;
  assign out_free   = !out_valid || out_ch.ready;
  assign step       = active && (!emit || out_free);
  assign flush_last = hold_count == nes_pkg::CNT_W'(1);

  // start code seen across the held bytes and the incoming one
  assign cut = slicing && (cur_offset >= nes_pkg::CUT_MIN_OFFSET) && (hold[1] == 8'h00)
               && (hold[2] == 8'h00) && (hold[3] == 8'h00) && (push_byte == nes_pkg::SC_ONE);

  assign emit_last = flushing ? flush_last : cut;
  assign emit_end  = flushing && flush_last;

  always_comb begin
    rd_ready = 1'b0;
    if (step) begin
      unique case (state)
        ST_HEAD:  rd_ready = !rd_data.start_code && !rd_data.epb && !rd_data.last;
        ST_SC:    rd_ready = 1'b0;
        ST_BYTE:  rd_ready = !rd_data.last;
        ST_FLUSH: rd_ready = flush_last;
        default:  rd_ready = 1'b0;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_valid;
  assign out_ch.out_byte      = out_byte;
  assign out_ch.slice_index   = out_index;
  assign out_ch.slice_last    = out_last;
  assign out_ch.frame_end     = out_end;
  assign out_ch.key_frame_out = out_key;
  assign out_ch.sequence_out  = out_seq;

  // hold-back shift line
  always_ff @(posedge clk) begin
    if (step && do_push) begin
      if (full) begin
        hold[0] <= hold[1];
        hold[1] <= hold[2];
        hold[2] <= hold[3];
        hold[3] <= push_byte;
      end else begin
        hold[cur_count[1:0]] <= push_byte;
      end
    end else if (step && flushing) begin
      hold[0] <= hold[1];
      hold[1] <= hold[2];
      hold[2] <= hold[3];
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_byte  <= hold[0];
      out_index <= cur_counter;
      out_last  <= emit_last;
      out_end   <= emit_end;
      out_key   <= cur_key;
      out_seq   <= cur_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_HEAD;
      sc_idx        <= 2'd0;
      hold_count    <= '0;
      slice_offset  <= 3'd0;
      slice_counter <= 16'd0;
      key_held      <= 1'b0;
      seq_held      <= 16'd0;
      slicing       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        slicing <= cfg_ch.slicing_enabled;
      end

      if (step && emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (step) begin
        if (fresh) begin
          key_held <= rd_data.key;
          seq_held <= rd_data.seq;
        end

        if (do_push) begin
          if (full) begin
            slice_counter <= cur_counter + 16'(cut);
            if (cut) begin
              slice_offset <= 3'd0;
            end else if (cur_offset != nes_pkg::OFFSET_MAX) begin
              slice_offset <= cur_offset + 3'd1;
            end
          end else begin
            hold_count    <= cur_count + 1'b1;
            slice_offset  <= cur_offset;
            slice_counter <= cur_counter;
          end
        end else begin
          hold_count <= hold_count - 1'b1;
          if (flush_last) begin
            slice_offset <= 3'd0;
          end
        end

        unique case (state)
          ST_HEAD: begin
            if (rd_data.start_code) begin
              state  <= ST_SC;
              sc_idx <= 2'd1;
            end else if (rd_data.epb) begin
              state <= ST_BYTE;
            end else if (rd_data.last) begin
              state <= ST_FLUSH;
            end
          end
          ST_SC: begin
            if (sc_idx == 2'd3) begin
              state <= ST_BYTE;
            end else begin
              sc_idx <= sc_idx + 2'd1;
            end
          end
          ST_BYTE: begin
            state <= rd_data.last ? ST_FLUSH : ST_HEAD;
          end
          ST_FLUSH: begin
            if (flush_last) begin
              state <= ST_HEAD;
            end
          end
          default: state <= ST_HEAD;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_hold_bound: assert property (@(posedge clk) disable iff (rst)
    hold_count <= nes_pkg::CNT_W'(nes_pkg::HOLD_DEPTH))
    else $error("hold-back count above depth");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (hold_count != '0))
    else $error("flush with nothing held");

  a_frame_end_drains: assert property (@(posedge clk) disable iff (rst)
    (step && emit && emit_end) |=> (hold_count == '0 && slice_offset == 3'd0
                                    && state == ST_HEAD))
    else $error("frame end left bytes held");

  a_no_emit_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> $stable(out_byte) && $stable(out_index))
    else $error("output beat overwritten while stalled");
`endif

endmodule

// ----- rtl/core/nal_escape_and_slice_splitter_top.sv -----
// nal_escape_and_slice_splitter_top: emulation prevention and start code slicing of a byte stream
// depends on nes_pkg, nes_in_if, nes_out_if, nes_cfg_if, nes_front, nes_fifo and nes_back
//
// usage:
//   in_ch carries one frame byte per beat with frame_first/frame_last and the frame flags,
//   which are taken from the first beat of each frame. out_ch carries one stream byte per
//   beat with its slice index, slice_last, frame_end, key flag and sequence number.
//   cfg_ch writes slicing_enabled; it is always ready and is meant to be written while idle.
// throughput: one input beat per cycle for plain bytes while out_ch is not stalled. each
//   inserted byte (the four byte start code, an 0x03 prevention byte) and each byte drained
//   at frame end takes a back end step of its own; a four entry queue lets the front keep
//   accepting while the back end works through those.
// path: a beat is written into the queue and read back from it before the back end pushes it
//   into the four byte hold-back. a push that finds the hold-back full loads the oldest byte
//   into the output register at the same edge. at frame end the held bytes drain one per
//   cycle while out_ch is not stalled.
// reset: rst (synchronous) empties the queue and hold-back, closes any open frame and
//   clears slicing_enabled. a stalled out_ch holds its beat; the back end stops once the
//   hold-back must emit, and the queue then back-pressures in_ch.
module nal_escape_and_slice_splitter_top (
  input  logic      clk,
  input  logic      rst,
  nes_in_if.sink    in_ch,
  nes_cfg_if.sink   cfg_ch,
  nes_out_if.source out_ch
);

  nes_pkg::nes_op_t front_op;
  logic             front_valid;
  logic             front_ready;
  nes_pkg::nes_op_t queue_op;
  logic             queue_valid;
  logic             queue_ready;

  nes_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .op       (front_op),
    .op_valid (front_valid),
    .op_ready (front_ready)
  );

  nes_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_op),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_data  (queue_op)
  );

  nes_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_data  (queue_op),
    .cfg_ch   (cfg_ch),
    .out_ch   (out_ch)
  );

endmodule
